FILE: rtl/sps_pkg.sv
// Shared constants, types and character helpers for the pattern search block.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;
  localparam int PATTERN_MAX = 32;   // power of two: window index is a mask
  localparam int SOURCE_MAX  = 128;
  localparam int PIDX_W = $clog2(PATTERN_MAX);
  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int SCNT_W = $clog2(SOURCE_MAX + 1);
  localparam int POS_W  = 7;

  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_SOURCE  = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_UA     = 8'h41;

  typedef enum logic [1:0] {OP_PAT, OP_SRC, OP_END, OP_NONE} op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } entry_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_lower(c) || is_upper(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction
endpackage
`default_nettype wire

FILE: rtl/sps_front.sv
// Front stage: registers incoming items and classifies them into operations.
`timescale 1ns / 1ps
`default_nettype none
module sps_front import sps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] byte_value,
  output logic            push,
  output entry_t          push_entry,
  input  wire logic       q_full
);
  logic   hold_valid;
  entry_t hold;

  assign push       = hold_valid && !q_full;
  assign push_entry = hold;
  assign in_stall   = hold_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      // drop items of an unknown kind here
      hold_valid <= in_valid && ((kind == KIND_PATTERN) || (kind == KIND_SOURCE)
                                 || (kind == KIND_END));
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      hold.data <= byte_value;
      case (kind)
        KIND_PATTERN: hold.op <= OP_PAT;
        KIND_SOURCE:  hold.op <= OP_SRC;
        KIND_END:     hold.op <= OP_END;
        default:      hold.op <= OP_NONE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sps_queue.sv
// Two-entry queue between front and back stages.
`timescale 1ns / 1ps
`default_nettype none
module sps_queue import sps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        q_valid,
  output entry_t      head
);
  entry_t     slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end
endmodule
`default_nettype wire

FILE: rtl/sps_back.sv
// Back stage: pattern load, source window and the element-by-element match walk.
`timescale 1ns / 1ps
`default_nettype none
module sps_back import sps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire entry_t      head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [POS_W-1:0] start_position
);
  typedef enum logic [2:0] {S_IDLE, S_ELEM, S_ESC, S_CLS_FIRST, S_CLS} state_t;
  typedef enum logic [1:0] {PH_NORMAL, PH_ESC, PH_CLASS} phase_t;

  logic [7:0] pattern_store [PATTERN_MAX];
  logic [7:0] source_window [PATTERN_MAX];

  state_t            state;
  phase_t            phase;
  logic [PLEN_W-1:0] plen;
  logic [PLEN_W-1:0] ecount;
  logic [SCNT_W-1:0] scount;
  logic              match_done;
  logic              loading;
  logic [PLEN_W-1:0] j;
  logic [PLEN_W-1:0] k;
  logic [SCNT_W-1:0] start;
  logic              neg;
  logic              member;

  logic              out_free;
  logic [7:0]        pat_byte;
  logic [7:0]        wchar;
  logic [SCNT_W-1:0] wsum;
  logic [SCNT_W-1:0] scount_inc;
  logic [SCNT_W-1:0] ecount_ext;
  logic              j_in;
  logic              pat_we;
  logic              src_we;

  assign out_free   = !out_valid || !out_stall;
  assign pop        = (state == S_IDLE) && q_valid && out_free;
  assign pat_byte   = pattern_store[j[PIDX_W-1:0]];
  assign wsum       = start + SCNT_W'(k);
  assign wchar      = source_window[wsum[PIDX_W-1:0]];
  assign scount_inc = scount + 1'b1;
  assign ecount_ext = SCNT_W'(ecount);
  assign j_in       = (j < plen);
  assign pat_we     = pop && (head.op == OP_PAT) && loading && (plen < PLEN_W'(PATTERN_MAX));
  assign src_we     = pop && (head.op == OP_SRC) && !match_done
                      && (scount < SCNT_W'(SOURCE_MAX));

  always_ff @(posedge clk) begin
    if (pat_we) pattern_store[plen[PIDX_W-1:0]] <= head.data;
    if (src_we) source_window[scount[PIDX_W-1:0]] <= head.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_NORMAL;
      plen       <= '0;
      ecount     <= '0;
      scount     <= '0;
      match_done <= 1'b0;
      loading    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_PAT: begin
                if (pat_we) begin
                  plen <= plen + 1'b1;
                  case (phase)
                    PH_ESC:   phase <= PH_NORMAL;
                    PH_CLASS: if (head.data == CH_RBRACK) phase <= PH_NORMAL;
                    default: begin
                      ecount <= ecount + 1'b1;
                      if (head.data == CH_BSLASH) phase <= PH_ESC;
                      else if (head.data == CH_LBRACK) phase <= PH_CLASS;
                    end
                  endcase
                end
              end
              OP_SRC: begin
                loading <= 1'b0;
                if (src_we) begin
                  scount <= scount_inc;
                  if (ecount == '0) begin
                    match_done     <= 1'b1;
                    out_valid      <= 1'b1;
                    found          <= 1'b1;
                    start_position <= '0;
                  end else if (scount_inc >= ecount_ext) begin
                    start <= scount_inc - ecount_ext;
                    j     <= '0;
                    k     <= '0;
                    state <= S_ELEM;
                  end
                end
              end
              OP_END: begin
                phase      <= PH_NORMAL;
                plen       <= '0;
                ecount     <= '0;
                scount     <= '0;
                match_done <= 1'b0;
                loading    <= 1'b1;
                if (!match_done) begin
                  out_valid      <= 1'b1;
                  found          <= 1'b0;
                  start_position <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_ELEM: begin
          if (k >= ecount) begin
            // whole window matched; wait for the output register
            if (out_free) begin
              match_done     <= 1'b1;
              out_valid      <= 1'b1;
              found          <= 1'b1;
              start_position <= start[POS_W-1:0];
              state          <= S_IDLE;
            end
          end else if (!j_in) begin
            state <= S_IDLE;
          end else begin
            j <= j + 1'b1;
            if (pat_byte == CH_DOT) begin
              k <= k + 1'b1;
            end else if (pat_byte == CH_BSLASH) begin
              state <= S_ESC;
            end else if (pat_byte == CH_LBRACK) begin
              state <= S_CLS_FIRST;
            end else if (is_alnum(pat_byte) && (pat_byte == wchar)) begin
              k <= k + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ESC: begin
          if (j_in && (((pat_byte == CH_LA) && is_lower(wchar))
                       || ((pat_byte == CH_UA) && is_upper(wchar)))) begin
            j     <= j + 1'b1;
            k     <= k + 1'b1;
            state <= S_ELEM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLS_FIRST: begin
          member <= 1'b0;
          neg    <= j_in && (pat_byte == CH_CARET);
          if (j_in && (pat_byte == CH_CARET)) j <= j + 1'b1;
          state  <= S_CLS;
        end
        S_CLS: begin
          if (j_in && (pat_byte != CH_RBRACK)) begin
            if (pat_byte == wchar) member <= 1'b1;
            j <= j + 1'b1;
          end else begin
            if (j_in) j <= j + 1'b1;
            if (neg ^ member) begin
              k     <= k + 1'b1;
              state <= S_ELEM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/simple_pattern_search.sv
// Top level of the streaming pattern search block.
//
//  channel | handshake          | fields
//  input   | in_valid/in_stall  | kind[1:0], byte_value[7:0]
//  output  | out_valid/out_stall| found, start_position[6:0]
//
// A pattern byte or end of source is handled as it is taken in the idle state.
// A source byte that fills a window starts a walk over the pattern store,
// one pattern byte per cycle, with an S_CLS_FIRST state for each class
// and a last step that waits for a free output; no item is taken meanwhile.
// Synchronous reset clears the pattern and the source; the stores keep data.
// A stalled output holds the back stage only when it has a result to give.
`timescale 1ns / 1ps
`default_nettype none
module simple_pattern_search import sps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       kind,
  input  wire logic [7:0]       byte_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  found,
  output logic [POS_W-1:0]      start_position
);
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   q_valid;
  entry_t head;

  sps_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .byte_value,
    .push, .push_entry, .q_full
  );

  sps_queue u_queue (
    .clk, .rst, .push, .push_entry, .full(q_full), .pop, .q_valid, .head
  );

  sps_back u_back (
    .clk, .rst, .q_valid, .head, .pop, .out_valid, .out_stall, .found, .start_position
  );
endmodule
`default_nettype wire

FILE: rtl/sps_checker.sv
// Port-level checks for the pattern search block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sps_props import sps_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             found,
  input wire logic [POS_W-1:0] start_position
);
  a_notfound_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> start_position == '0)
    else $error("not-found result with nonzero position");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("activity straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(found) && $stable(start_position))
    else $error("stalled result changed");
endmodule

bind simple_pattern_search sps_props u_sps_props (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .found, .start_position
);
`default_nettype wire

FILE: tb/sps_checker.sv
// Checker for the pattern search block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
`default_nettype none
module sps_checker import sps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [1:0]       kind,
  input  wire logic [7:0]       byte_value,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic             found,
  input  wire logic [POS_W-1:0] start_position,
  output int                    fail_count,
  output int                    pending
);
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } verdict_t;

  logic [7:0] pat_mem [PATTERN_MAX];
  logic [7:0] win_mem [PATTERN_MAX];
  int unsigned pat_len, elem_cnt, src_cnt;
  int unsigned phase;
  bit done, loading;
  verdict_t verdicts [$];

  assign pending = verdicts.size();

  function automatic bit is_letter_lo(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic bit is_letter_up(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  // Test c against the element at pos; advance pos past the element.
  function automatic bit elem_hit(ref int unsigned pos, input logic [7:0] c);
    logic [7:0] e;
    bit neg, member, hit;
    e = pat_mem[pos];
    hit = 0;
    neg = 0;
    member = 0;
    pos++;
    if (e == CH_DOT) begin
      hit = 1;
    end else if (e == CH_BSLASH) begin
      if (pos < pat_len) begin
        hit = (pat_mem[pos] == CH_LA && is_letter_lo(c)) ||
              (pat_mem[pos] == CH_UA && is_letter_up(c));
        pos++;
      end
    end else if (e == CH_LBRACK) begin
      if (pos < pat_len && pat_mem[pos] == CH_CARET) begin
        neg = 1;
        pos++;
      end
      while (pos < pat_len && pat_mem[pos] != CH_RBRACK) begin
        if (pat_mem[pos] == c) member = 1;
        pos++;
      end
      if (pos < pat_len) pos++;
      hit = neg ? !member : member;
    end else if (is_letter_lo(e) || is_letter_up(e) || (e >= "0" && e <= "9")) begin
      hit = (e == c);
    end
    return hit;
  endfunction

  function automatic bit window_hit(int unsigned first);
    int unsigned j;
    j = 0;
    for (int unsigned k = 0; k < elem_cnt; k++) begin
      if (j >= pat_len) return 0;
      if (!elem_hit(j, win_mem[(first + k) % PATTERN_MAX])) return 0;
    end
    return 1;
  endfunction

  task automatic clear_search();
    pat_len = 0;
    elem_cnt = 0;
    src_cnt = 0;
    phase = 0;
    done = 0;
    loading = 1;
  endtask

  task automatic predict(logic [1:0] k, logic [7:0] b);
    int unsigned first;
    bit report;
    if (k == KIND_PATTERN) begin
      if (!loading || pat_len >= PATTERN_MAX) return;
      pat_mem[pat_len] = b;
      pat_len++;
      if (phase == 1) begin
        phase = 0;
      end else if (phase == 2) begin
        if (b == CH_RBRACK) phase = 0;
      end else begin
        elem_cnt++;
        if (b == CH_BSLASH) phase = 1;
        else if (b == CH_LBRACK) phase = 2;
      end
    end else if (k == KIND_SOURCE) begin
      loading = 0;
      if (done || src_cnt >= SOURCE_MAX) return;
      win_mem[src_cnt % PATTERN_MAX] = b;
      src_cnt++;
      if (elem_cnt == 0) begin
        done = 1;
        verdicts.push_back('{1'b1, '0});
      end else if (src_cnt >= elem_cnt) begin
        first = src_cnt - elem_cnt;
        if (window_hit(first)) begin
          done = 1;
          verdicts.push_back('{1'b1, first[POS_W-1:0]});
        end
      end
    end else if (k == KIND_END) begin
      report = !done;
      clear_search();
      if (report) verdicts.push_back('{1'b0, '0});
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    clear_search();
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      clear_search();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected item found=%0b pos=%0d",
                                    found, start_position));
        end else begin
          v = verdicts.pop_front();
          if (found !== v.hit)
            report_mismatch($sformatf("found %0b, want %0b", found, v.hit));
          if (start_position !== v.pos)
            report_mismatch($sformatf("position %0d, want %0d", start_position, v.pos));
        end
      end
      if (in_valid && !in_stall) predict(kind, byte_value);
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench top for the pattern search block: stimulus, reset and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sps_pkg::*;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, found;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [POS_W-1:0] start_position;
  int fail_count, pending;
  bit calm;

  simple_pattern_search dut (.*);

  sps_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && $urandom_range(99) < 17;
  endfunction

  // Receiver stalls at random.
  initial begin
    out_stall = 1;
    forever begin
      @(negedge clk);
      out_stall = rst ? 1'b0 : idle_now();
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(logic [1:0] k, logic [7:0] b);
    while (idle_now()) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    kind = k;
    byte_value = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(logic [1:0] k, string s);
    for (int i = 0; i < s.len(); i++) send(k, s[i]);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return 8'($urandom_range("a", "d"));
      3, 4: return 8'($urandom_range("A", "C"));
      5: return 8'($urandom_range("0", "2"));
      6: return CH_RBRACK;
      default: return 8'($urandom_range("a", "z"));
    endcase
  endfunction

  function automatic logic [7:0] pick_elem_char();
    case ($urandom_range(11))
      0: return CH_DOT;
      1: return CH_BSLASH;
      2: return CH_LBRACK;
      3: return CH_CARET;
      4: return 8'($urandom_range(255));
      default: return pick_char();
    endcase
  endfunction

  // Pattern of n element forms; a picked character may be a special one, so it is not always well-formed.
  task automatic send_pattern(int n);
    int sz;
    for (int e = 0; e < n; e++) begin
      case ($urandom_range(7))
        0: send(KIND_PATTERN, CH_DOT);
        1: begin
          send(KIND_PATTERN, CH_BSLASH);
          send(KIND_PATTERN, $urandom_range(1) ? CH_LA : CH_UA);
        end
        2, 3: begin
          send(KIND_PATTERN, CH_LBRACK);
          if ($urandom_range(1)) send(KIND_PATTERN, CH_CARET);
          sz = $urandom_range(3);
          for (int i = 0; i < sz; i++) send(KIND_PATTERN, pick_char());
          send(KIND_PATTERN, CH_RBRACK);
        end
        default: send(KIND_PATTERN, pick_char());
      endcase
    end
  endtask

  int sent, n;

  initial begin
    rst = 1;
    in_valid = 0;
    kind = KIND_PATTERN;
    byte_value = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: each element form, empty pattern, class edges, overlong inputs.
    send_str(KIND_PATTERN, "a\\A[xy][^0-].");
    send_str(KIND_SOURCE, "zzaBxz!Q");
    send(KIND_END, 0);
    send(KIND_END, 0);
    send(KIND_SOURCE, 8'h00);
    send(KIND_END, 0);
    send_str(KIND_PATTERN, "[]");
    send_str(KIND_SOURCE, "]a");
    send(KIND_END, 0);
    send_str(KIND_PATTERN, "[^]\\");
    send_str(KIND_SOURCE, "ab");
    send(KIND_END, 0);
    send_str(KIND_PATTERN, "\\x[ab");
    send_str(KIND_SOURCE, "xa");
    send(KIND_PATTERN, "q");
    send(KIND_END, 0);
    send(2'd3, 8'hFF);
    for (int i = 0; i < 34; i++) send(KIND_PATTERN, CH_DOT);
    for (int i = 0; i < 31; i++) send(KIND_SOURCE, 8'hFF);
    send(KIND_SOURCE, 8'h80);
    send(KIND_END, 0);
    send(KIND_PATTERN, "9");
    for (int i = 0; i < 130; i++) send(KIND_SOURCE, i == 129 ? "9" : (i == 127 ? "9" : "0"));
    send(KIND_END, 0);
    send(KIND_PATTERN, 8'hFF);
    send(KIND_SOURCE, 8'hFF);
    send(KIND_END, 0);

    // Random searches, with a calm stretch in the middle.
    sent = 0;
    while (sent < 1100) begin
      calm = (sent > 400 && sent < 650);
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) send(2'($urandom_range(3)), pick_elem_char());
        sent += n;
      end else begin
        n = $urandom_range(1, 4);
        if ($urandom_range(15) == 0) n = $urandom_range(10, 20);
        send_pattern(n);
        sent += 2 * n;
      end
      n = $urandom_range(1, 24);
      if ($urandom_range(30) == 0) n = 135;
      for (int i = 0; i < n; i++) send(KIND_SOURCE, pick_char());
      send(KIND_END, 0);
      sent += n + 1;
    end
    in_valid = 0;
    calm = 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_queue.sv
rtl/sps_back.sv
rtl/simple_pattern_search.sv
rtl/sps_checker.sv
tb/sps_checker.sv
tb/tb_top.sv
